>>> hdl/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset masked
`define ASSERT_IMPL(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// next-cycle implication, reset masked
`define ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

>>> hdl/pfik_pkg.sv
// ----------------------------------------------------------------------------
// pfik_pkg
// shared types and constants of the planar fabrik solver
// ----------------------------------------------------------------------------
package pfik_pkg;

    localparam int LEN_W = 15;
    localparam int TOL_W = 12;
    localparam int STATUS_W = 2;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
    localparam logic [STATUS_W-1:0] ST_LOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOCONV = 2'd2;

    localparam logic [2:0] REG_BASE_X = 3'd0;
    localparam logic [2:0] REG_BASE_Y = 3'd1;
    localparam logic [2:0] REG_LINK_ONE = 3'd2;
    localparam logic [2:0] REG_LINK_TWO = 3'd3;
    localparam logic [2:0] REG_TOL = 3'd4;
    localparam logic [2:0] REG_MIN_HEIGHT = 3'd5;
    localparam logic [2:0] REG_HEIGHT_OFF = 3'd6;

    typedef struct packed {
        logic start;
        logic place;
    } pfik_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } pfik_sts_t;

endpackage

>>> hdl/pfik_if.sv
// ----------------------------------------------------------------------------
// pfik_in_if / pfik_out_if
// valid/ready channels for target beats and solution beats
// ----------------------------------------------------------------------------
interface pfik_in_if #(
    parameter int COORD_WIDTH = 16
);
    logic valid;
    logic ready;
    logic signed [COORD_WIDTH-1:0] target_x;
    logic signed [COORD_WIDTH-1:0] target_y;
    logic signed [COORD_WIDTH-1:0] target_z;

    modport source (output valid, target_x, target_y, target_z, input ready);
    modport sink (input valid, target_x, target_y, target_z, output ready);
endinterface

interface pfik_out_if #(
    parameter int COORD_WIDTH = 16
);
    logic valid;
    logic ready;
    logic [1:0] status;
    logic signed [COORD_WIDTH-1:0] base_height;
    logic signed [COORD_WIDTH-1:0] elbow_x_out;
    logic signed [COORD_WIDTH-1:0] elbow_y_out;
    logic signed [COORD_WIDTH-1:0] end_x_out;
    logic signed [COORD_WIDTH-1:0] end_y_out;

    modport source (output valid, status, base_height, elbow_x_out, elbow_y_out,
                    end_x_out, end_y_out, input ready);
    modport sink (input valid, status, base_height, elbow_x_out, elbow_y_out,
                  end_x_out, end_y_out, output ready);
endinterface

>>> hdl/pfik_geom.sv
// ----------------------------------------------------------------------------
// pfik_geom
// shared length / joint placement unit: multiplier, bit-serial root, divider
// ----------------------------------------------------------------------------
module pfik_geom #(
    parameter int COORD_WIDTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  pfik_pkg::pfik_ctl_t ctl,
    output pfik_pkg::pfik_sts_t sts,
    input  logic signed [COORD_WIDTH-1:0] fx,
    input  logic signed [COORD_WIDTH-1:0] fy,
    input  logic signed [COORD_WIDTH-1:0] px,
    input  logic signed [COORD_WIDTH-1:0] py,
    input  logic [pfik_pkg::LEN_W-1:0] len,
    output logic [(2*COORD_WIDTH+4)/2:0] r,
    output logic signed [COORD_WIDTH-1:0] ox,
    output logic signed [COORD_WIDTH-1:0] oy
);
    import pfik_pkg::*;
    `include "assert_macros.svh"

    localparam int CW = COORD_WIDTH;
    localparam int DW = CW + 1;
    localparam int MAW = (DW > LEN_W) ? DW : LEN_W;
    localparam int PW = 2 * MAW;
    localparam int SW = 2 * DW + 1;
    localparam int NB = (SW + 1) / 2;
    localparam int RW = NB + 1;
    localparam int NW = PW + 1;
    localparam int XW = NW + 2;
    localparam int CNTW = $clog2(NW + 1);

    localparam logic [3:0] G_IDLE = 4'd0;
    localparam logic [3:0] G_MX = 4'd1;
    localparam logic [3:0] G_MY = 4'd2;
    localparam logic [3:0] G_ADD = 4'd3;
    localparam logic [3:0] G_SQRT = 4'd4;
    localparam logic [3:0] G_ROOT = 4'd5;
    localparam logic [3:0] G_MUL = 4'd6;
    localparam logic [3:0] G_NUM = 4'd7;
    localparam logic [3:0] G_DIV = 4'd8;
    localparam logic [3:0] G_FIX = 4'd9;
    localparam logic [3:0] G_DONE = 4'd10;

    localparam logic signed [XW-1:0] SMAX = {{(XW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [XW-1:0] SMIN = {{(XW-CW+1){1'b1}}, {(CW-1){1'b0}}};

    function automatic logic signed [CW-1:0] sat(input logic signed [XW-1:0] v);
        if (v > SMAX)
        begin
            return SMAX[CW-1:0];
        end
        else if (v < SMIN)
        begin
            return SMIN[CW-1:0];
        end
        return v[CW-1:0];
    endfunction

    logic [3:0] state_reg, state_next;
    logic place_reg;
    logic axis_reg;
    logic signed [CW-1:0] fx_reg, fy_reg;
    logic signed [DW-1:0] dx_reg, dy_reg;
    logic [LEN_W-1:0] len_reg;
    logic [PW-1:0] mul_reg;
    logic [SW-1:0] sum_reg;
    logic [2*NB-1:0] sq_v_reg, sq_res_reg, sq_bit_reg;
    logic [RW-1:0] r_reg;
    logic [NW-1:0] q_reg;
    logic [RW:0] rem_reg;
    logic [CNTW-1:0] cnt_reg;
    logic signed [CW-1:0] ox_reg, oy_reg;

    logic [DW-1:0] ax, ay, ax_h, ay_h, ad;
    logic huge;
    logic [MAW-1:0] mul_a, mul_b;
    logic [2*NB-1:0] sq_try;
    logic [RW:0] rem_sh;
    logic signed [XW-1:0] f_ext, q_ext, fix_sum;
    logic d_neg;

    always_comb
    begin
        ax = dx_reg[DW-1] ? DW'(-dx_reg) : dx_reg;
        ay = dy_reg[DW-1] ? DW'(-dy_reg) : dy_reg;
        huge = (64'(ax) >= 64'h8000_0000) || (64'(ay) >= 64'h8000_0000);
        ax_h = huge ? (ax >> 1) : ax;
        ay_h = huge ? (ay >> 1) : ay;
        ad = axis_reg ? ay : ax;
        d_neg = axis_reg ? dy_reg[DW-1] : dx_reg[DW-1];
        case (state_reg)
            G_MX:
            begin
                mul_a = MAW'(ax_h);
                mul_b = MAW'(ax_h);
            end
            G_MY:
            begin
                mul_a = MAW'(ay_h);
                mul_b = MAW'(ay_h);
            end
            default:
            begin
                mul_a = MAW'(len_reg);
                mul_b = MAW'(ad);
            end
        endcase
        sq_try = sq_res_reg + sq_bit_reg;
        rem_sh = {rem_reg[RW-1:0], q_reg[NW-1]};
        f_ext = axis_reg ? XW'(fy_reg) : XW'(fx_reg);
        q_ext = XW'(q_reg);
        fix_sum = d_neg ? (f_ext - q_ext) : (f_ext + q_ext);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            G_IDLE: if (ctl.start) state_next = G_MX;
            G_MX: state_next = G_MY;
            G_MY: state_next = G_ADD;
            G_ADD: state_next = G_SQRT;
            G_SQRT: if (cnt_reg == CNTW'(NB - 1)) state_next = G_ROOT;
            G_ROOT:
            begin
                if (!place_reg)
                begin
                    state_next = G_DONE;
                end
                else if (huge ? (sq_res_reg == '0) : (sq_res_reg == '0))
                begin
                    state_next = G_DONE;
                end
                else
                begin
                    state_next = G_MUL;
                end
            end
            G_MUL: state_next = G_NUM;
            G_NUM: state_next = G_DIV;
            G_DIV: if (cnt_reg == CNTW'(NW - 1)) state_next = G_FIX;
            G_FIX: state_next = axis_reg ? G_DONE : G_MUL;
            G_DONE: state_next = G_IDLE;
            default: state_next = G_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= G_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            G_IDLE:
            begin
                if (ctl.start)
                begin
                    place_reg <= ctl.place;
                    fx_reg <= fx;
                    fy_reg <= fy;
                    dx_reg <= DW'(px) - DW'(fx);
                    dy_reg <= DW'(py) - DW'(fy);
                    len_reg <= len;
                    axis_reg <= 1'b0;
                end
            end
            G_MX:
            begin
                mul_reg <= PW'(mul_a) * PW'(mul_b);
            end
            G_MY:
            begin
                sum_reg <= SW'(mul_reg);
                mul_reg <= PW'(mul_a) * PW'(mul_b);
            end
            G_ADD:
            begin
                sq_v_reg <= (2*NB)'(sum_reg + SW'(mul_reg));
                sq_res_reg <= '0;
                sq_bit_reg <= (2*NB)'(1) << (2*NB - 2);
                cnt_reg <= '0;
            end
            G_SQRT:
            begin
                if (sq_v_reg >= sq_try)
                begin
                    sq_v_reg <= sq_v_reg - sq_try;
                    sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                end
                else
                begin
                    sq_res_reg <= sq_res_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
                cnt_reg <= cnt_reg + 1'b1;
            end
            G_ROOT:
            begin
                // root doubled back when the halved differences were used
                r_reg <= huge ? {sq_res_reg[NB-1:0], 1'b0} : RW'(sq_res_reg[NB-1:0]);
                if (place_reg && sq_res_reg == '0)
                begin
                    ox_reg <= sat(XW'(fx_reg) + XW'(len_reg));
                    oy_reg <= fy_reg;
                end
            end
            G_MUL:
            begin
                mul_reg <= PW'(mul_a) * PW'(mul_b);
            end
            G_NUM:
            begin
                q_reg <= NW'(mul_reg) + NW'(r_reg >> 1);
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            G_DIV:
            begin
                if (rem_sh >= (RW+1)'(r_reg))
                begin
                    rem_reg <= rem_sh - (RW+1)'(r_reg);
                    q_reg <= {q_reg[NW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    q_reg <= {q_reg[NW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
            G_FIX:
            begin
                if (axis_reg)
                begin
                    oy_reg <= sat(fix_sum);
                end
                else
                begin
                    ox_reg <= sat(fix_sum);
                end
                axis_reg <= 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign sts.busy = (state_reg != G_IDLE);
    assign sts.done = (state_reg == G_DONE);
    assign r = r_reg;
    assign ox = ox_reg;
    assign oy = oy_reg;

    `ASSERT_NEXT(a_geom_start_runs, clk, rst_n, ctl.start && state_reg == G_IDLE, state_reg == G_MX, "start not taken")
    `ASSERT_IMPL(a_geom_div_bound, clk, rst_n, state_reg == G_DIV, rem_reg < (RW+1)'(r_reg), "remainder out of range")
    `ASSERT_NEXT(a_geom_done_idle, clk, rst_n, state_reg == G_DONE, state_reg == G_IDLE, "done not followed by idle")

endmodule

>>> hdl/planar_fabrik_ik_solver.sv
// ----------------------------------------------------------------------------
// planar_fabrik_ik_solver
// three-joint planar chain solved by fabrik against a target point
// ----------------------------------------------------------------------------
// One target beat is taken at a time and in_ch.ready stays low until its
// solution is written to the output register. Work runs on one shared unit
// (one multiplier, a bit-serial square root, a restoring divider) that
// finds a length or places one joint. A rejected target takes no work
// on the unit, a stretched chain takes a length and two placements, and a
// reachable one runs up to MAX_ITER passes. The output register holds a
// finished beat while the next target is being solved.
module planar_fabrik_ik_solver #(
    parameter int MAX_ITER = 16,
    parameter int COORD_WIDTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [pfik_pkg::ADDR_W-1:0] paddr,
    input  logic [pfik_pkg::DATA_W-1:0] pwdata,
    output logic [pfik_pkg::DATA_W-1:0] prdata,
    output logic pready,
    pfik_in_if.sink in_ch,
    pfik_out_if.source out_ch
);
    import pfik_pkg::*;
    `include "assert_macros.svh"

    localparam int CW = COORD_WIDTH;
    localparam int DW = CW + 1;
    localparam int SW = 2 * DW + 1;
    localparam int NB = (SW + 1) / 2;
    localparam int RW = NB + 1;
    localparam int PCW = $clog2(MAX_ITER + 1);

    // sequencer states
    localparam logic [3:0] T_IDLE = 4'd0;
    localparam logic [3:0] T_CHK = 4'd1;
    localparam logic [3:0] T_W0 = 4'd2;
    localparam logic [3:0] T_S1 = 4'd3;
    localparam logic [3:0] T_S2 = 4'd4;
    localparam logic [3:0] T_D = 4'd5;
    localparam logic [3:0] T_LOOP = 4'd6;
    localparam logic [3:0] T_P1 = 4'd7;
    localparam logic [3:0] T_P2 = 4'd8;
    localparam logic [3:0] T_P3 = 4'd9;
    localparam logic [3:0] T_OUT = 4'd10;

    function automatic logic signed [CW-1:0] sat_const(input longint v);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (CW - 1)) - 1;
        lo = -(64'sd1 <<< (CW - 1));
        if (v > hi)
        begin
            return CW'(hi);
        end
        else if (v < lo)
        begin
            return CW'(lo);
        end
        return CW'(v);
    endfunction

    localparam logic signed [CW-1:0] RST_BASE_X = sat_const(560);
    localparam logic signed [CW-1:0] RST_MIN_H = sat_const(2608);
    localparam logic signed [CW-1:0] RST_H_OFF = sat_const(208);
    localparam logic signed [CW-1:0] RST_ELBOW_X = sat_const(2960);
    localparam logic signed [CW-1:0] RST_END_X = sat_const(3200);
    localparam logic signed [CW-1:0] RST_BASE_Z = sat_const(2816);

    // configuration registers
    logic signed [CW-1:0] base_x_reg, base_y_reg, min_h_reg, h_off_reg;
    logic [LEN_W-1:0] l1_reg, l2_reg;
    logic [TOL_W-1:0] tol_reg;

    // chain state and working registers
    logic [3:0] state_reg, state_next;
    logic signed [CW-1:0] tx_reg, ty_reg, tz_reg;
    logic signed [CW-1:0] elbow_x_reg, elbow_y_reg, end_x_reg, end_y_reg, base_z_reg;
    logic [PCW-1:0] pass_reg;
    logic [RW-1:0] diff_reg;
    logic [STATUS_W-1:0] status_reg;

    // shared unit request
    pfik_ctl_t ctl_reg;
    pfik_sts_t sts;
    logic signed [CW-1:0] op_fx_reg, op_fy_reg, op_px_reg, op_py_reg;
    logic [LEN_W-1:0] op_len_reg;
    logic [RW-1:0] g_r;
    logic signed [CW-1:0] g_ox, g_oy;

    // output register
    logic out_valid_reg;
    logic [STATUS_W-1:0] o_status_reg;
    logic signed [CW-1:0] o_bz_reg, o_ex_reg, o_ey_reg, o_nx_reg, o_ny_reg;

    logic cfg_wr;
    logic [2:0] cfg_idx;
    logic signed [CW:0] bz_sum;
    logic signed [CW-1:0] bz_sat;
    logic keep_going;
    logic reach_far;
    logic out_free;

    pfik_geom #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_geom (
        .clk(clk),
        .rst_n(rst_n),
        .ctl(ctl_reg),
        .sts(sts),
        .fx(op_fx_reg),
        .fy(op_fy_reg),
        .px(op_px_reg),
        .py(op_py_reg),
        .len(op_len_reg),
        .r(g_r),
        .ox(g_ox),
        .oy(g_oy)
    );

    // apb port: always ready, index from the word address
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_comb
    begin
        case (cfg_idx)
            REG_BASE_X: prdata = DATA_W'(base_x_reg);
            REG_BASE_Y: prdata = DATA_W'(base_y_reg);
            REG_LINK_ONE: prdata = DATA_W'(l1_reg);
            REG_LINK_TWO: prdata = DATA_W'(l2_reg);
            REG_TOL: prdata = DATA_W'(tol_reg);
            REG_MIN_HEIGHT: prdata = DATA_W'(min_h_reg);
            REG_HEIGHT_OFF: prdata = DATA_W'(h_off_reg);
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_x_reg <= RST_BASE_X;
            base_y_reg <= '0;
            l1_reg <= LEN_W'(2400);
            l2_reg <= LEN_W'(240);
            tol_reg <= TOL_W'(32);
            min_h_reg <= RST_MIN_H;
            h_off_reg <= RST_H_OFF;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_BASE_X: base_x_reg <= pwdata[CW-1:0];
                REG_BASE_Y: base_y_reg <= pwdata[CW-1:0];
                REG_LINK_ONE: l1_reg <= pwdata[LEN_W-1:0];
                REG_LINK_TWO: l2_reg <= pwdata[LEN_W-1:0];
                REG_TOL: tol_reg <= pwdata[TOL_W-1:0];
                REG_MIN_HEIGHT: min_h_reg <= pwdata[CW-1:0];
                REG_HEIGHT_OFF: h_off_reg <= pwdata[CW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // new base height, saturated
    always_comb
    begin
        bz_sum = (CW+1)'(tz_reg) + (CW+1)'(h_off_reg);
        if (bz_sum[CW] != bz_sum[CW-1])
        begin
            bz_sat = bz_sum[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end
        else
        begin
            bz_sat = bz_sum[CW-1:0];
        end
    end

    assign reach_far = 64'(g_r) > (64'(l1_reg) + 64'(l2_reg));
    assign keep_going = (64'(diff_reg) > 64'(tol_reg)) && (64'(pass_reg) < 64'(MAX_ITER));
    assign out_free = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            T_IDLE: if (in_ch.valid) state_next = T_CHK;
            T_CHK: state_next = (tz_reg < min_h_reg) ? T_OUT : T_W0;
            T_W0: if (sts.done) state_next = reach_far ? T_S1 : T_D;
            T_S1: if (sts.done) state_next = T_S2;
            T_S2: if (sts.done) state_next = T_OUT;
            T_D: if (sts.done) state_next = T_LOOP;
            T_LOOP: state_next = keep_going ? T_P1 : T_OUT;
            T_P1: if (sts.done) state_next = T_P2;
            T_P2: if (sts.done) state_next = T_P3;
            T_P3: if (sts.done) state_next = T_D;
            T_OUT: if (out_free) state_next = T_IDLE;
            default: state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            ctl_reg <= '0;
            out_valid_reg <= 1'b0;
            elbow_x_reg <= RST_ELBOW_X;
            elbow_y_reg <= '0;
            end_x_reg <= RST_END_X;
            end_y_reg <= '0;
            base_z_reg <= RST_BASE_Z;
            pass_reg <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            ctl_reg.start <= 1'b0;
            if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                T_IDLE:
                begin
                    status_reg <= ST_OK;
                    pass_reg <= '0;
                end
                T_CHK:
                begin
                    if (tz_reg < min_h_reg)
                    begin
                        status_reg <= ST_LOW;
                    end
                    else
                    begin
                        // length base to target
                        base_z_reg <= bz_sat;
                        ctl_reg <= '{start: 1'b1, place: 1'b0};
                        op_fx_reg <= base_x_reg;
                        op_fy_reg <= base_y_reg;
                        op_px_reg <= tx_reg;
                        op_py_reg <= ty_reg;
                    end
                end
                T_W0:
                begin
                    if (sts.done)
                    begin
                        if (reach_far)
                        begin
                            // out of reach: stretch, elbow first
                            ctl_reg <= '{start: 1'b1, place: 1'b1};
                            op_fx_reg <= base_x_reg;
                            op_fy_reg <= base_y_reg;
                            op_px_reg <= tx_reg;
                            op_py_reg <= ty_reg;
                            op_len_reg <= l1_reg;
                        end
                        else
                        begin
                            // current miss distance
                            ctl_reg <= '{start: 1'b1, place: 1'b0};
                            op_fx_reg <= tx_reg;
                            op_fy_reg <= ty_reg;
                            op_px_reg <= end_x_reg;
                            op_py_reg <= end_y_reg;
                        end
                    end
                end
                T_S1:
                begin
                    if (sts.done)
                    begin
                        elbow_x_reg <= g_ox;
                        elbow_y_reg <= g_oy;
                        ctl_reg <= '{start: 1'b1, place: 1'b1};
                        op_fx_reg <= g_ox;
                        op_fy_reg <= g_oy;
                        op_px_reg <= tx_reg;
                        op_py_reg <= ty_reg;
                        op_len_reg <= l2_reg;
                    end
                end
                T_S2:
                begin
                    if (sts.done)
                    begin
                        end_x_reg <= g_ox;
                        end_y_reg <= g_oy;
                    end
                end
                T_D:
                begin
                    if (sts.done)
                    begin
                        diff_reg <= g_r;
                    end
                end
                T_LOOP:
                begin
                    if (keep_going)
                    begin
                        // backward pass: end to target, elbow toward old elbow
                        end_x_reg <= tx_reg;
                        end_y_reg <= ty_reg;
                        ctl_reg <= '{start: 1'b1, place: 1'b1};
                        op_fx_reg <= tx_reg;
                        op_fy_reg <= ty_reg;
                        op_px_reg <= elbow_x_reg;
                        op_py_reg <= elbow_y_reg;
                        op_len_reg <= l2_reg;
                    end
                    else if (64'(diff_reg) > 64'(tol_reg))
                    begin
                        status_reg <= ST_NOCONV;
                    end
                end
                T_P1:
                begin
                    if (sts.done)
                    begin
                        // forward pass: elbow from the base
                        elbow_x_reg <= g_ox;
                        elbow_y_reg <= g_oy;
                        ctl_reg <= '{start: 1'b1, place: 1'b1};
                        op_fx_reg <= base_x_reg;
                        op_fy_reg <= base_y_reg;
                        op_px_reg <= g_ox;
                        op_py_reg <= g_oy;
                        op_len_reg <= l1_reg;
                    end
                end
                T_P2:
                begin
                    if (sts.done)
                    begin
                        // end point from the new elbow toward the target
                        elbow_x_reg <= g_ox;
                        elbow_y_reg <= g_oy;
                        ctl_reg <= '{start: 1'b1, place: 1'b1};
                        op_fx_reg <= g_ox;
                        op_fy_reg <= g_oy;
                        op_px_reg <= end_x_reg;
                        op_py_reg <= end_y_reg;
                        op_len_reg <= l2_reg;
                    end
                end
                T_P3:
                begin
                    if (sts.done)
                    begin
                        end_x_reg <= g_ox;
                        end_y_reg <= g_oy;
                        pass_reg <= pass_reg + 1'b1;
                        ctl_reg <= '{start: 1'b1, place: 1'b0};
                        op_fx_reg <= tx_reg;
                        op_fy_reg <= ty_reg;
                        op_px_reg <= g_ox;
                        op_py_reg <= g_oy;
                    end
                end
                T_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // target capture and the output beat
    always_ff @(posedge clk)
    begin
        if (state_reg == T_IDLE && in_ch.valid)
        begin
            tx_reg <= in_ch.target_x;
            ty_reg <= in_ch.target_y;
            tz_reg <= in_ch.target_z;
        end
        if (state_reg == T_OUT && out_free)
        begin
            o_status_reg <= status_reg;
            o_bz_reg <= base_z_reg;
            o_ex_reg <= elbow_x_reg;
            o_ey_reg <= elbow_y_reg;
            o_nx_reg <= end_x_reg;
            o_ny_reg <= end_y_reg;
        end
    end

    assign in_ch.ready = (state_reg == T_IDLE);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.status = o_status_reg;
    assign out_ch.base_height = o_bz_reg;
    assign out_ch.elbow_x_out = o_ex_reg;
    assign out_ch.elbow_y_out = o_ey_reg;
    assign out_ch.end_x_out = o_nx_reg;
    assign out_ch.end_y_out = o_ny_reg;

    `ASSERT_IMPL(a_start_when_free, clk, rst_n, ctl_reg.start, !sts.busy, "shared unit started while busy")
    `ASSERT_IMPL(a_pass_bound, clk, rst_n, 1'b1, 64'(pass_reg) <= 64'(MAX_ITER), "pass count beyond limit")
    `ASSERT_NEXT(a_busy_after_beat, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready, "second beat taken while solving")
    `ASSERT_IMPL(a_status_code, clk, rst_n, out_valid_reg, o_status_reg != 2'd3, "undefined status code")

endmodule
